FILE: src/ehp_pkg.sv
// Shared types and constants for the Ethernet/IPv4 header parser.
// No dependencies; imported by every module of the parser.
`timescale 1ns / 1ps
`default_nettype none

package ehp_pkg;

  // Frame layout
  localparam int unsigned ETH_HDR_BYTES     = 14;
  localparam int unsigned IP_MIN_HDR_BYTES  = 20;
  localparam int unsigned ICMP_HDR_BYTES    = 8;
  localparam int unsigned UDP_HDR_BYTES     = 8;
  localparam int unsigned TCP_MIN_HDR_BYTES = 20;
  localparam int unsigned TCP_OFFSET_POS    = 12;
  localparam int unsigned MIN_IP_FRAME      = ETH_HDR_BYTES + IP_MIN_HDR_BYTES;

  // Capture positions within the frame
  localparam logic [15:0] POS_ETYPE_HI = 16'd12;
  localparam logic [15:0] POS_ETYPE_LO = 16'd13;
  localparam logic [15:0] POS_VER_IHL  = 16'd14;
  localparam logic [15:0] POS_TLEN_HI  = 16'd16;
  localparam logic [15:0] POS_TLEN_LO  = 16'd17;
  localparam logic [15:0] POS_PROTO    = 16'd23;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;

  // IPv4 protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Verdict codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_SMALL = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE  = 2'd2;
  localparam logic [1:0] ST_BAD_FIELD = 2'd3;

  // Transport kinds
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_ICMP  = 2'd1;
  localparam logic [1:0] KIND_TCP   = 2'd2;
  localparam logic [1:0] KIND_UDP   = 2'd3;

  // Frame queue depth
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Header fields of one finished frame
  typedef struct packed {
    logic [15:0] last_pos;   // index of the final byte (length minus one)
    logic [15:0] eth_type;
    logic [7:0]  ver_ihl;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [3:0]  tcp_nib;
    logic        tcp_seen;
  } frame_rec_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage : ehp_pkg

`default_nettype wire

FILE: src/ehp_front.sv
// Byte-stream front end: tracks position, captures header fields.
// Pushes one frame record per final byte. Depends on ehp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ehp_front import ehp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_take,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output frame_rec_t      rec,
  output logic            push
);

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [7:0]  vihl_r, vihl_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [3:0]  tnib_r, tnib_nxt;
  logic        tseen_r, tseen_nxt;

  logic [15:0] cap_etype, cap_tlen, tcp_pos;
  logic [7:0]  cap_vihl, cap_proto;
  logic [3:0]  cap_tnib;
  logic        cap_tseen;
  logic [5:0]  ihl_bytes;

  // Capture this byte into the field it belongs to
  always_comb begin
    ihl_bytes = {vihl_r[3:0], 2'b00};
    tcp_pos   = 16'(ETH_HDR_BYTES + TCP_OFFSET_POS) + {10'd0, ihl_bytes};
    cap_etype = etype_r;
    cap_vihl  = vihl_r;
    cap_tlen  = tlen_r;
    cap_proto = proto_r;
    cap_tnib  = tnib_r;
    cap_tseen = tseen_r;
    if (pos_r == POS_ETYPE_HI) cap_etype[15:8] = data_byte;
    if (pos_r == POS_ETYPE_LO) cap_etype[7:0]  = data_byte;
    if (pos_r == POS_VER_IHL)  cap_vihl        = data_byte;
    if (pos_r == POS_TLEN_HI)  cap_tlen[15:8]  = data_byte;
    if (pos_r == POS_TLEN_LO)  cap_tlen[7:0]   = data_byte;
    if (pos_r == POS_PROTO)    cap_proto       = data_byte;
    if (pos_r > POS_VER_IHL && pos_r == tcp_pos) begin
      cap_tnib  = data_byte[7:4];
      cap_tseen = 1'b1;
    end
  end

  // Build the record and the next frame state
  always_comb begin
    rec.last_pos   = pos_r;
    rec.eth_type   = cap_etype;
    rec.ver_ihl    = cap_vihl;
    rec.total_len  = cap_tlen;
    rec.proto      = cap_proto;
    rec.tcp_nib    = cap_tnib;
    rec.tcp_seen   = cap_tseen;
    push           = byte_take & last_byte;

    pos_nxt   = pos_r;
    etype_nxt = etype_r;
    vihl_nxt  = vihl_r;
    tlen_nxt  = tlen_r;
    proto_nxt = proto_r;
    tnib_nxt  = tnib_r;
    tseen_nxt = tseen_r;
    if (byte_take) begin
      if (last_byte) begin
        pos_nxt   = '0;
        etype_nxt = '0;
        vihl_nxt  = '0;
        tlen_nxt  = '0;
        proto_nxt = '0;
        tnib_nxt  = '0;
        tseen_nxt = 1'b0;
      end else begin
        pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + 16'd1;
        etype_nxt = cap_etype;
        vihl_nxt  = cap_vihl;
        tlen_nxt  = cap_tlen;
        proto_nxt = cap_proto;
        tnib_nxt  = cap_tnib;
        tseen_nxt = cap_tseen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      etype_r <= '0;
      vihl_r  <= '0;
      tlen_r  <= '0;
      proto_r <= '0;
      tnib_r  <= '0;
      tseen_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      etype_r <= etype_nxt;
      vihl_r  <= vihl_nxt;
      tlen_r  <= tlen_nxt;
      proto_r <= proto_nxt;
      tnib_r  <= tnib_nxt;
      tseen_r <= tseen_nxt;
    end
  end

  // A finished frame leaves no state behind for the next one
  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (pos_r == '0 && tseen_r == 1'b0 && etype_r == '0))
    else $error("frame state not cleared after final byte");

endmodule : ehp_front

`default_nettype wire

FILE: src/ehp_queue.sv
// Short queue of frame records between front end and verdict stage.
// Depends on ehp_pkg (record type, depth constants).
`timescale 1ns / 1ps
`default_nettype none

module ehp_queue import ehp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire frame_rec_t push_rec,
  input  wire logic       pop,
  output frame_rec_t      head_rec,
  output q_stat_t         stat
);

  frame_rec_t mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  always_comb begin
    stat.full      = (cnt_r == QCNT_W'(QDEPTH));
    stat.not_empty = (cnt_r != '0);
    do_push        = push & ~stat.full;
    do_pop         = pop & stat.not_empty;
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (do_push) wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    if (do_pop)  rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  assign head_rec = mem_r[rptr_r];

  // Store records
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_rec;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("record pushed into full queue");

endmodule : ehp_queue

`default_nettype wire

FILE: src/ehp_back.sv
// Verdict stage: runs the header checks on one frame record and
// holds the result in the output register. Depends on ehp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ehp_back import ehp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire q_stat_t    qstat,
  input  wire frame_rec_t rec,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [1:0] out_parse_status,
  output logic [1:0] out_transport_kind,
  output logic [7:0] out_ip_protocol,
  output logic [7:0] out_payload_offset,
  output logic [15:0] out_payload_length
);

  logic        valid_r, valid_nxt;
  logic [1:0]  status_r, kind_r;
  logic [7:0]  proto_r, off_r;
  logic [15:0] plen_r;

  logic [1:0]  st, kind;
  logic [7:0]  off, off_base;
  logic [15:0] plen, p;
  logic [5:0]  h, t;

  // Run the checks in order; the first failing one decides
  always_comb begin
    h        = {rec.ver_ihl[3:0], 2'b00};
    t        = {rec.tcp_nib, 2'b00};
    p        = rec.total_len - {10'd0, h};
    off_base = 8'(ETH_HDR_BYTES) + {2'b00, h};
    st   = ST_OK;
    kind = KIND_OTHER;
    off  = '0;
    plen = '0;
    priority if (rec.last_pos < 16'(ETH_HDR_BYTES - 1)) begin
      st = ST_TOO_SMALL;
    end else if (rec.eth_type != ETHERTYPE_IPV4) begin
      st = ST_BAD_TYPE;
    end else if (rec.last_pos < 16'(MIN_IP_FRAME - 1)) begin
      st = ST_TOO_SMALL;
    end else if (rec.ver_ihl[7:4] != IP_VERSION_4) begin
      st = ST_BAD_FIELD;
    end else if (h < 6'(IP_MIN_HDR_BYTES)
                 || rec.last_pos < 16'(ETH_HDR_BYTES - 1) + {10'd0, h}
                 || rec.total_len < {10'd0, h}) begin
      st = ST_TOO_SMALL;
    end else if (rec.proto == PROTO_ICMP || rec.proto == PROTO_UDP) begin
      if (p < 16'(ICMP_HDR_BYTES)) begin
        st = ST_TOO_SMALL;
      end else begin
        kind = (rec.proto == PROTO_ICMP) ? KIND_ICMP : KIND_UDP;
        off  = off_base + 8'(UDP_HDR_BYTES);
        plen = p - 16'(UDP_HDR_BYTES);
      end
    end else if (rec.proto == PROTO_TCP) begin
      priority if (p < 16'(TCP_MIN_HDR_BYTES) || !rec.tcp_seen) begin
        st = ST_TOO_SMALL;
      end else if (t < 6'(TCP_MIN_HDR_BYTES) || p < {10'd0, t}) begin
        st = ST_BAD_FIELD;
      end else begin
        kind = KIND_TCP;
        off  = off_base + {2'b00, t};
        plen = p - {10'd0, t};
      end
    end else begin
      off  = off_base;
      plen = p;
    end
  end

  // Load a new verdict whenever the output register is free or being drained
  always_comb begin
    pop       = qstat.not_empty & (~valid_r | out_ready);
    valid_nxt = valid_r;
    if (pop)                      valid_nxt = 1'b1;
    else if (valid_r & out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= st;
      kind_r   <= kind;
      proto_r  <= rec.proto;
      off_r    <= off;
      plen_r   <= plen;
    end
  end

  assign out_valid          = valid_r;
  assign out_parse_status   = status_r;
  assign out_transport_kind = kind_r;
  assign out_ip_protocol    = proto_r;
  assign out_payload_offset = off_r;
  assign out_payload_length = plen_r;

  // A TCP verdict always covers the Ethernet, IP and TCP minimum headers
  a_tcp_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r == ST_OK && kind_r == KIND_TCP)
      |-> off_r >= 8'(MIN_IP_FRAME + TCP_MIN_HDR_BYTES))
    else $error("TCP payload offset below minimum headers");

endmodule : ehp_back

`default_nettype wire

FILE: src/ethernet_ipv4_header_parser.sv
// Top level of the Ethernet/IPv4 header parser.
// Instantiates ehp_front, ehp_queue and ehp_back; depends on ehp_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one frame byte per transfer in wire
//   order, in_last_byte set on the final byte of a frame.
//   Output channel (out_valid/out_ready): one verdict per frame, carrying
//   status, transport kind, IP protocol and payload offset/length.
//   Throughput: one byte per cycle. The front end only waits when the
//   two-entry frame queue is full, which happens only when the receiver
//   stalls across the ends of three frames.
//   Verdict path: the transfer of the final byte writes the frame record into
//   the queue, then the verdict register loads it when the output is free.
//   Reset (rst_n low, synchronous): frame state, queue and output valid
//   clear; the first byte after reset starts a new frame.
//   Receiver stall: the verdict holds in the output register; up to two
//   more frames queue behind it, then in_ready drops on the next frame.
`timescale 1ns / 1ps
`default_nettype none

module ethernet_ipv4_header_parser import ehp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_parse_status,
  output logic [1:0]       out_transport_kind,
  output logic [7:0]       out_ip_protocol,
  output logic [7:0]       out_payload_offset,
  output logic [15:0]      out_payload_length
);

  frame_rec_t push_rec, head_rec;
  q_stat_t    qstat;
  logic       push, pop, byte_take;

  // Accept bytes as long as a finished frame can be queued
  assign in_ready  = ~qstat.full;
  assign byte_take = in_valid & in_ready;

  ehp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .rec       (push_rec),
    .push      (push)
  );

  ehp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (qstat)
  );

  ehp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .qstat              (qstat),
    .rec                (head_rec),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_parse_status   (out_parse_status),
    .out_transport_kind (out_transport_kind),
    .out_ip_protocol    (out_ip_protocol),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length)
  );

endmodule : ethernet_ipv4_header_parser

`default_nettype wire

FILE: dv/ehp_verdict_checker.sv
`timescale 1ns / 1ps
// Verdict checker for the Ethernet/IPv4 header parser: follows frame bytes on
// the input channel, predicts each verdict, and checks it on the output channel.
// Depends on ehp_pkg for verdict codes, protocol numbers and frame layout.

module ehp_verdict_checker import ehp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_parse_status,
  input  logic [1:0]  out_transport_kind,
  input  logic [7:0]  out_ip_protocol,
  input  logic [7:0]  out_payload_offset,
  input  logic [15:0] out_payload_length,
  output int          fail_count,
  output int          verdicts_pending,
  output int          verdicts_checked,
  output int          ok_verdicts
);

  localparam int unsigned WORD_BYTES  = 4;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  kind;
    logic [7:0]  proto;
    logic [7:0]  offset;
    logic [15:0] length;
  } verdict_t;

  // Header fields of the frame in flight
  logic [15:0] byte_count;
  logic [15:0] eth_type;
  logic [7:0]  ver_ihl;
  logic [15:0] total_len;
  logic [7:0]  proto_byte;
  logic [3:0]  tcp_nib;
  logic        tcp_nib_seen;

  verdict_t    expected_verdicts[$];
  int unsigned mismatches;
  int unsigned strays;
  int unsigned checked;
  int unsigned ok_seen;

  function automatic void clear_frame();
    byte_count   = '0;
    eth_type     = '0;
    ver_ihl      = '0;
    total_len    = '0;
    proto_byte   = '0;
    tcp_nib      = '0;
    tcp_nib_seen = 1'b0;
  endfunction

  // Verdict for a frame of frame_len bytes, from the captured header fields
  function automatic verdict_t predict_verdict(input int unsigned frame_len);
    verdict_t    v;
    int unsigned ip_hdr;
    int unsigned ip_pay;
    int unsigned tcp_hdr;
    v        = '0;
    v.status = ST_OK;
    v.kind   = KIND_OTHER;
    v.proto  = proto_byte;
    ip_hdr   = WORD_BYTES * ver_ihl[3:0];
    tcp_hdr  = WORD_BYTES * tcp_nib;
    if (frame_len < ETH_HDR_BYTES) v.status = ST_TOO_SMALL;
    else if (eth_type != ETHERTYPE_IPV4) v.status = ST_BAD_TYPE;
    else if (frame_len < MIN_IP_FRAME) v.status = ST_TOO_SMALL;
    else if (ver_ihl[7:4] != IP_VERSION_4) v.status = ST_BAD_FIELD;
    else if (ip_hdr < IP_MIN_HDR_BYTES || frame_len < ETH_HDR_BYTES + ip_hdr ||
             total_len < ip_hdr) v.status = ST_TOO_SMALL;
    else begin
      ip_pay = total_len - ip_hdr;
      case (proto_byte)
        PROTO_ICMP: begin
          if (ip_pay < ICMP_HDR_BYTES) v.status = ST_TOO_SMALL;
          else begin
            v.kind   = KIND_ICMP;
            v.offset = 8'(ETH_HDR_BYTES + ip_hdr + ICMP_HDR_BYTES);
            v.length = 16'(ip_pay - ICMP_HDR_BYTES);
          end
        end
        PROTO_UDP: begin
          if (ip_pay < UDP_HDR_BYTES) v.status = ST_TOO_SMALL;
          else begin
            v.kind   = KIND_UDP;
            v.offset = 8'(ETH_HDR_BYTES + ip_hdr + UDP_HDR_BYTES);
            v.length = 16'(ip_pay - UDP_HDR_BYTES);
          end
        end
        PROTO_TCP: begin
          // a frame that stops before the data-offset byte is too small
          if (ip_pay < TCP_MIN_HDR_BYTES || !tcp_nib_seen) v.status = ST_TOO_SMALL;
          else if (tcp_hdr < TCP_MIN_HDR_BYTES || ip_pay < tcp_hdr) v.status = ST_BAD_FIELD;
          else begin
            v.kind   = KIND_TCP;
            v.offset = 8'(ETH_HDR_BYTES + ip_hdr + tcp_hdr);
            v.length = 16'(ip_pay - tcp_hdr);
          end
        end
        default: begin
          v.offset = 8'(ETH_HDR_BYTES + ip_hdr);
          v.length = 16'(ip_pay);
        end
      endcase
    end
    return v;
  endfunction

  always @(posedge clk) begin : track
    verdict_t    got;
    verdict_t    want;
    int unsigned pos;
    int unsigned tcp_pos;
    if (!rst_n) begin
      clear_frame();
      expected_verdicts.delete();
    end else begin
      // compare a verdict transfer with the oldest prediction
      if (out_valid && out_ready) begin
        got = {out_parse_status, out_transport_kind, out_ip_protocol,
               out_payload_offset, out_payload_length};
        if (expected_verdicts.size() == 0) begin
          strays++;
          if (mismatches + strays <= MAX_REPORTS)
            $display("%0t: unexpected verdict status=%0d kind=%0d proto=%0d off=%0d len=%0d",
                     $time, got.status, got.kind, got.proto, got.offset, got.length);
        end else begin
          want = expected_verdicts.pop_front();
          checked++;
          if (want.status == ST_OK) ok_seen++;
          if (got !== want) begin
            mismatches++;
            if (mismatches + strays <= MAX_REPORTS) begin
              $display("%0t: verdict %0d mismatch", $time, checked);
              $display("  expected status=%0d kind=%0d proto=%0d off=%0d len=%0d",
                       want.status, want.kind, want.proto, want.offset, want.length);
              $display("  actual   status=%0d kind=%0d proto=%0d off=%0d len=%0d",
                       got.status, got.kind, got.proto, got.offset, got.length);
            end
          end
        end
      end

      // capture header fields as the frame streams in
      if (in_valid && in_ready) begin
        pos     = byte_count;
        tcp_pos = ETH_HDR_BYTES + WORD_BYTES * ver_ihl[3:0] + TCP_OFFSET_POS;
        if (pos == POS_ETYPE_HI) eth_type[15:8]   = in_data_byte;
        if (pos == POS_ETYPE_LO) eth_type[7:0]    = in_data_byte;
        if (pos == POS_VER_IHL)  ver_ihl          = in_data_byte;
        if (pos == POS_TLEN_HI)  total_len[15:8]  = in_data_byte;
        if (pos == POS_TLEN_LO)  total_len[7:0]   = in_data_byte;
        if (pos == POS_PROTO)    proto_byte       = in_data_byte;
        if (pos > POS_VER_IHL && pos == tcp_pos) begin
          tcp_nib      = in_data_byte[7:4];
          tcp_nib_seen = 1'b1;
        end
        // saturate the count on very long frames
        if (byte_count != POS_MAX) byte_count = byte_count + 16'd1;
        if (in_last_byte) begin
          expected_verdicts.push_back(predict_verdict(pos + 1));
          clear_frame();
        end
      end
    end
    fail_count       <= mismatches + strays;
    verdicts_pending <= expected_verdicts.size();
    verdicts_checked <= checked;
    ok_verdicts      <= ok_seen;
  end

endmodule

FILE: dv/tb_ethernet_ipv4_header_parser.sv
`timescale 1ns / 1ps
// Top of the header parser testbench: clock, reset, frame stimulus and the
// receiver's stall pattern. Depends on ehp_pkg, the parser and ehp_verdict_checker.

module tb_ethernet_ipv4_header_parser;
  import ehp_pkg::*;

  localparam int unsigned WORD_BYTES       = 4;
  localparam int unsigned BYTE_TARGET      = 1850;
  localparam int unsigned FRAME_TARGET     = 40;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES     = 8;

  typedef enum int unsigned {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_ready    = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_parse_status;
  logic [1:0]  out_transport_kind;
  logic [7:0]  out_ip_protocol;
  logic [7:0]  out_payload_offset;
  logic [15:0] out_payload_length;

  int          fail_count;
  int          verdicts_pending;
  int          verdicts_checked;
  int          ok_verdicts;
  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned burst_left;
  int unsigned idle_cycles;

  ethernet_ipv4_header_parser u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_parse_status   (out_parse_status),
    .out_transport_kind (out_transport_kind),
    .out_ip_protocol    (out_ip_protocol),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length)
  );

  ehp_verdict_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_parse_status   (out_parse_status),
    .out_transport_kind (out_transport_kind),
    .out_ip_protocol    (out_ip_protocol),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length),
    .fail_count         (fail_count),
    .verdicts_pending   (verdicts_pending),
    .verdicts_checked   (verdicts_checked),
    .ok_verdicts        (ok_verdicts)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one byte and hold it until the transfer; idle between bursts
  task automatic send_byte(input logic [7:0] data, input logic last);
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (last) frames_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Send a frame of len bytes with the given header fields; all else random
  task automatic send_frame(input logic [15:0] etype, input logic [7:0] vihl,
                            input logic [15:0] tlen, input logic [7:0] proto,
                            input logic [7:0] tcp_byte, input int unsigned len);
    int unsigned tcp_pos;
    logic [7:0]  data;
    tcp_pos = ETH_HDR_BYTES + WORD_BYTES * vihl[3:0] + TCP_OFFSET_POS;
    for (int unsigned i = 0; i < len; i++) begin
      data = 8'($urandom);
      if (i == POS_ETYPE_HI) data = etype[15:8];
      if (i == POS_ETYPE_LO) data = etype[7:0];
      if (i == POS_VER_IHL)  data = vihl;
      if (i == POS_TLEN_HI)  data = tlen[15:8];
      if (i == POS_TLEN_LO)  data = tlen[7:0];
      if (i == POS_PROTO)    data = proto;
      if (i == tcp_pos)      data = tcp_byte;
      send_byte(data, i == len - 1);
    end
  endtask

  // Mostly well-formed IPv4 frames; some corrupted, truncated, padded or noise
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned ihl;
    int unsigned ip_hdr;
    int unsigned xport_hdr;
    int unsigned len;
    logic [3:0]  tcp_nib;
    logic [7:0]  proto;
    logic [7:0]  vihl;
    logic [7:0]  tcp_byte;
    logic [15:0] etype;
    logic [15:0] tlen;
    pick    = $urandom_range(0, 99);
    ihl     = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
    ip_hdr  = WORD_BYTES * ihl;
    tcp_nib = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
    case ($urandom_range(0, 3))
      0:       proto = PROTO_ICMP;
      1:       proto = PROTO_TCP;
      2:       proto = PROTO_UDP;
      default: proto = 8'($urandom);
    endcase
    if (proto == PROTO_TCP) xport_hdr = WORD_BYTES * tcp_nib;
    else if (proto == PROTO_ICMP || proto == PROTO_UDP) xport_hdr = ICMP_HDR_BYTES;
    else xport_hdr = 0;
    tlen     = 16'(ip_hdr + xport_hdr + $urandom_range(0, 16));
    len      = ETH_HDR_BYTES + tlen;
    etype    = ETHERTYPE_IPV4;
    vihl     = {IP_VERSION_4, 4'(ihl)};
    tcp_byte = {tcp_nib, 4'($urandom)};
    if (pick < 12) begin
      // pure noise
      etype    = 16'($urandom);
      vihl     = 8'($urandom);
      tlen     = 16'($urandom);
      proto    = 8'($urandom);
      tcp_byte = 8'($urandom);
      len      = $urandom_range(1, 60);
    end else if (pick < 32) begin
      // break one field
      case ($urandom_range(0, 4))
        0:       etype    = 16'($urandom);
        1:       vihl[7:4] = 4'($urandom);
        2:       vihl[3:0] = 4'($urandom);
        3:       tlen     = 16'($urandom);
        default: tcp_byte = 8'($urandom);
      endcase
    end else if (pick < 42) begin
      len = $urandom_range(1, len);
    end else if (pick < 50) begin
      len = len + $urandom_range(1, 20);
    end
    send_frame(etype, vihl, tlen, proto, tcp_byte, len);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst_left = $urandom_range(1, 24);

    // short frames and each early rejection
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'd28, PROTO_UDP, 8'h50, 1);
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'd28, PROTO_UDP, 8'h50, 13);
    send_frame(16'h86DD, 8'h45, 16'd28, PROTO_UDP, 8'h50, 14);
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'd28, PROTO_UDP, 8'h50, 14);
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'd28, PROTO_UDP, 8'h50, 33);
    send_frame(ETHERTYPE_IPV4, 8'h65, 16'd28, PROTO_UDP, 8'h50, 34);
    // IP header too short, beyond the frame, or longer than total length
    send_frame(ETHERTYPE_IPV4, 8'h44, 16'd28, PROTO_UDP, 8'h50, 60);
    send_frame(ETHERTYPE_IPV4, 8'h4F, 16'd100, PROTO_UDP, 8'h50, 60);
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'd19, PROTO_UDP, 8'h50, 34);
    // ICMP and UDP at the payload limit; transport beyond the frame is allowed
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'd27, PROTO_ICMP, 8'h50, 60);
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'd28, PROTO_ICMP, 8'h50, 42);
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'd27, PROTO_UDP, 8'h50, 60);
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'hFFFF, PROTO_UDP, 8'h50, 42);
    // TCP: short payload, frame ends before data offset, bad offsets, extremes
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'd39, PROTO_TCP, 8'h50, 60);
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'd60, PROTO_TCP, 8'h50, 40);
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'd60, PROTO_TCP, 8'h40, 60);
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'd60, PROTO_TCP, 8'hF0, 74);
    send_frame(ETHERTYPE_IPV4, 8'h4F, 16'd125, PROTO_TCP, 8'hFF, 139);
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'd40, PROTO_TCP, 8'h5F, 47);
    // other protocols pass the IP payload straight through
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'd20, 8'hFF, 8'h00, 34);
    send_frame(ETHERTYPE_IPV4, 8'h45, 16'hFFFF, 8'h00, 8'hFF, 34);

    while (bytes_sent < BYTE_TARGET || frames_sent < FRAME_TARGET)
      send_random_frame();
    in_valid <= 1'b0;

    // drain outstanding verdicts
    @(negedge clk);
    while (verdicts_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d frames (%0d bytes): corner frames, random IPv4 traffic,",
             frames_sent, bytes_sent);
    $display("corrupted and noise frames, receiver hold-offs; %0d verdicts, %0d ok.",
             verdicts_checked, ok_verdicts);
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("tb_ethernet_ipv4_header_parser OK");
    end else begin
      $display("tb_ethernet_ipv4_header_parser NOT OK");
    end
    $finish;
  end

  // Receiver: changing stall modes, plus two long hold-offs to back up the input
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned cadence;
    int unsigned verdicts_seen;
    mode          = RX_ALWAYS;
    mode_left     = 0;
    hold_left     = 0;
    cadence       = 0;
    verdicts_seen = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        verdicts_seen++;
        if (verdicts_seen == 10 || verdicts_seen == 30) hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      cadence++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          RX_ALWAYS:  out_ready <= 1'b1;
          RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
          default:    out_ready <= (cadence % 5 != 0);
        endcase
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_ethernet_ipv4_header_parser NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
